// ===== sv/i2w_pkg.sv =====
// Shared types and token codes for the integer-to-word-tokens block.
// Used by the front end, the item queue, the back end and the top level.
`default_nettype none

package i2w_pkg;

  localparam int VALUE_W    = 31;
  localparam int WORD_W     = 5;
  localparam int NUM_DIGITS = 10;

  typedef logic [3:0]                digit_t;
  typedef digit_t [NUM_DIGITS-1:0]   bcd_t;
  typedef logic [WORD_W-1:0]         word_t;

  localparam word_t TOK_ZERO     = 5'd0;
  localparam word_t TOK_TEN      = 5'd10;
  localparam word_t TOK_TENS_OFS = 5'd18;
  localparam word_t TOK_HUNDRED  = 5'd28;

endpackage

`default_nettype wire

// ===== sv/i2w_front.sv =====
// Front end: accepts a value and converts it to ten BCD digits by shift-and-add-3,
// one bit per cycle. Depends on i2w_pkg.
`default_nettype none

module i2w_front import i2w_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    full,
  output logic                    q_push,
  output bcd_t                    q_data,
  input  wire logic               q_full
);

  localparam int CNT_W = $clog2(VALUE_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] shreg;
  bcd_t               bcd;
  bcd_t               adj;
  logic [4*NUM_DIGITS-1:0] adj_flat;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    adj_flat = adj;
  end

  assign full   = (state != ST_IDLE);
  assign q_push = (state == ST_PUSH);
  assign q_data = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (push) state <= ST_CONV;
        ST_CONV: if (cnt == '0) state <= ST_PUSH;
        ST_PUSH: if (!q_full) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && push) begin
      shreg <= value;
      bcd   <= '0;
      cnt   <= CNT_W'(VALUE_W - 1);
    end else if (state == ST_CONV) begin
      // shift the next value bit into the adjusted digits
      bcd   <= bcd_t'({adj_flat[4*NUM_DIGITS-2:0], shreg[VALUE_W-1]});
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2w_queue.sv =====
// Short queue of converted digit sets between front and back end.
// Depends on i2w_pkg.
`default_nettype none

module i2w_queue import i2w_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  bcd_t      wr_data,
  output logic      full,
  input  wire logic rd_en,
  output bcd_t      rd_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcd_t [DEPTH-1:0] entries;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== sv/i2w_back.sv =====
// Back end: walks the digit groups of one number and emits one word token per
// cycle into the output register while it is free. Depends on i2w_pkg.
`default_nettype none

module i2w_back import i2w_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  bcd_t      q_data,
  output logic      q_pop,
  output logic      empty,
  input  wire logic pop,
  output word_t     word,
  output logic      last_word
);

  // group index 3..0 (billions..units), digit index 2..0 (hundreds, tens, units)
  logic [3:0][2:0][3:0] dg;
  logic [3:0][2:0][3:0] load_dg;
  // slot mask per group: digit, Hundred, tens/teen, units, scale
  logic [3:0][4:0]      rem;
  logic [3:0][4:0]      load_rem;
  logic [3:0][4:0]      rem_clr;
  logic [1:0]           g;
  logic                 busy;
  logic                 ovalid;
  logic [4:0]           cur;
  logic [2:0]           slot;
  logic                 hit;
  logic                 out_free;
  logic [3:0]           h;
  logic [3:0]           t;
  logic [3:0]           u;
  word_t                tok;

  assign q_pop    = !busy && !q_empty;
  assign empty    = !ovalid;
  assign out_free = !ovalid || pop;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 3; j++) begin
        load_dg[k][j] = (3 * k + j < NUM_DIGITS) ? q_data[3 * k + j] : 4'd0;
      end
    end
    for (int k = 0; k < 4; k++) begin
      load_rem[k][0] = (load_dg[k][2] != 4'd0);
      load_rem[k][1] = (load_dg[k][2] != 4'd0);
      load_rem[k][2] = (load_dg[k][1] != 4'd0);
      load_rem[k][3] = (load_dg[k][1] != 4'd1) && (load_dg[k][0] != 4'd0);
      load_rem[k][4] = (k > 0) && (load_dg[k] != '0);
    end
    // zero: the billions hundreds slot holds digit 0, which reads as Zero
    if (load_dg == '0) load_rem[3][0] = 1'b1;
  end

  always_comb begin
    cur  = rem[g];
    hit  = |cur;
    slot = 3'd0;
    for (int s = 4; s >= 0; s--) begin
      if (cur[s]) slot = 3'(s);
    end
    h = dg[g][2];
    t = dg[g][1];
    u = dg[g][0];
    unique case (slot)
      3'd0:    tok = {1'b0, h};
      3'd1:    tok = TOK_HUNDRED;
      3'd2:    tok = (t == 4'd1) ? TOK_TEN + {1'b0, u} : TOK_TENS_OFS + {1'b0, t};
      3'd3:    tok = {1'b0, u};
      3'd4:    tok = TOK_HUNDRED + {3'b000, g};
      default: tok = TOK_ZERO;
    endcase
    rem_clr = rem;
    rem_clr[g][slot] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (q_pop) busy <= 1'b1;
      if (busy && hit && out_free) begin
        ovalid <= 1'b1;
        if (rem_clr == '0) busy <= 1'b0;
      end else if (ovalid && pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dg  <= load_dg;
      rem <= load_rem;
      g   <= 2'd3;
    end else if (busy) begin
      if (!hit) begin
        // nothing left in this group, move down
        g <= g - 2'd1;
      end else if (out_free) begin
        word      <= tok;
        last_word <= (rem_clr == '0);
        rem       <= rem_clr;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/integer_to_word_tokens_core.sv =====
// Spells a 31-bit unsigned value as a run of English word tokens.
// Input channel: drive value and raise push; the value is taken on an edge where
// push is high and full is low. full stays high while the front end converts.
// Result channel: while empty is low, word and last_word show the oldest token;
// it is taken on an edge where pop is high. last_word marks a number's final token.
// Steps: the front end loads the value and converts it to BCD, one value bit per
// cycle, then queues the digits; the back end loads them and emits one token per
// cycle while the output register is free, but spends a step with no token on
// moving down past each group that has nothing left. The front end takes a new
// value only after the previous one has been converted and written to the queue.
// Up to QUEUE_DEPTH converted numbers wait between the two parts.
// Reset (rst, synchronous) empties the queue and the output register and returns
// the front end to idle. When the receiver stalls, the output register holds its
// token, the back end waits, then the queue fills and finally full stays high.
`default_nettype none

module integer_to_word_tokens_core import i2w_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    empty,
  input  wire logic               pop,
  output logic [WORD_W-1:0]       word,
  output logic                    last_word
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  bcd_t q_wdata;
  bcd_t q_rdata;

  i2w_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .value  (value),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  i2w_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  i2w_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .word      (word),
    .last_word (last_word)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> (full && !q_push))
    else $error("front end not busy after accepting a value");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end loads from an empty queue");

  a_pop_queue_count: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_push) |=> !q_full)
    else $error("queue still full after a load with no push");

  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(word) && $stable(last_word)))
    else $error("output token changed while the receiver stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/integer_to_word_tokens_core_test.sv =====
// Self-checking testbench for integer_to_word_tokens_core.
// Predicts the English word tokens for each value sent and checks them token by token.
// Depends on i2w_pkg for widths and token codes.
module integer_to_word_tokens_core_test;
  import i2w_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t TOK_THOUSAND = 5'd29;
  localparam word_t TOK_MILLION  = 5'd30;
  localparam word_t TOK_BILLION  = 5'd31;
  localparam int    MAX_TOKENS   = 16;
  localparam int    HOLD_CYCLES  = 500;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    SETTLE_CYCLES = 60;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    word_t word;
    logic  last_word;
  } token_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               pop = 1'b0;
  logic               full;
  logic               empty;
  word_t              word;
  logic               last_word;

  token_t token_q[$];
  int     err_cnt = 0;
  int     n_values = 0;
  int     n_tokens = 0;
  bit     send_idle_on = 1'b1;
  bit     recv_idle_on = 1'b1;
  bit     hold_req = 1'b0;

  integer_to_word_tokens_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .word      (word),
    .last_word (last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append the expected token run for one value.
  function automatic void spell_value(input logic [VALUE_W-1:0] v);
    int unsigned num;
    int unsigned h;
    int unsigned t;
    int unsigned u;
    int unsigned grps[4];
    word_t       scale[4];
    word_t       toks[$];
    num = v;
    if (num == 0) begin
      token_q.push_back('{TOK_ZERO, 1'b1});
      return;
    end
    scale = '{5'd0, TOK_THOUSAND, TOK_MILLION, TOK_BILLION};
    grps[0] = num % 1000;
    grps[1] = (num / 1000) % 1000;
    grps[2] = (num / 1000000) % 1000;
    grps[3] = num / 1000000000;
    for (int g = 3; g >= 0; g--) begin
      if (grps[g] == 0) continue;
      h = grps[g] / 100;
      t = (grps[g] / 10) % 10;
      u = grps[g] % 10;
      if (h != 0) begin
        toks.push_back(word_t'(h));
        toks.push_back(TOK_HUNDRED);
      end
      if (t == 1) begin
        toks.push_back(TOK_TEN + word_t'(u));
      end else begin
        if (t != 0) toks.push_back(TOK_TENS_OFS + word_t'(t));
        if (u != 0) toks.push_back(word_t'(u));
      end
      if (g > 0) toks.push_back(scale[g]);
    end
    while (toks.size() > MAX_TOKENS) void'(toks.pop_back());
    foreach (toks[i]) token_q.push_back('{toks[i], i == toks.size() - 1});
  endfunction

  // Random three-digit group biased toward zero, teens and round hundreds.
  function automatic int unsigned rand_group();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return $urandom_range(10, 19);
      2: return $urandom_range(1, 9) * 100;
      3: return $urandom_range(1, 9) * 100 + $urandom_range(10, 19);
      default: return $urandom_range(1, 999);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    longint v;
    case ($urandom_range(0, 3))
      0: v = $urandom() & VALUE_MAX;
      1: v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 999);
      2: begin
        v = longint'($urandom_range(0, 2)) * 1000000000 + longint'(rand_group()) * 1000000
            + longint'(rand_group()) * 1000 + rand_group();
        if (v > VALUE_MAX) v = v - 1000000000;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = VALUE_MAX - $urandom_range(0, 999);
          1: v = 1000 + $urandom_range(0, 2) - 1;
          2: v = 1000000 + $urandom_range(0, 2) - 1;
          default: v = 1000000000 + $urandom_range(0, 2) - 1;
        endcase
      end
    endcase
    return v[VALUE_W-1:0];
  endfunction

  // Offer one value; return at the edge that takes it, push still high.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
    spell_value(v);
    n_values++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] vals[$];
    vals = '{0, 1, 9, 10, 11, 19, 20, 50, 99, 100, 110, 999, 1000, 1005, 12013014, 15016017,
             30405060, 70809000, 1000000, 1000000000, 1018000000, 1234567890, 1777777777,
             2000000001, VALUE_MAX};
    foreach (vals[i]) send_value(vals[i]);
    wait_drained();
  endtask

  task automatic test_random();
    for (int chunk = 0; chunk < 7; chunk++) begin
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
      repeat (10) send_value(rand_value());
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    wait_drained();
  endtask

  // Hold the receiver off while values keep coming, so full has to rise.
  task automatic test_backpressure();
    send_idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (8) send_value(rand_value());
    wait_drained();
    send_idle_on = 1'b1;
  endtask

  task automatic test_no_idle();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (15) send_value(rand_value());
    wait_drained();
  endtask

  // Receiver: check every token taken, then decide pop for the next edge.
  initial begin
    token_t exp_tok;
    int     stall_cnt;
    int     hold_cnt;
    stall_cnt = 0;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        n_tokens++;
        if (token_q.size() == 0) begin
          $error("unexpected token: word %0d last_word %0b", word, last_word);
          err_cnt++;
        end else begin
          exp_tok = token_q.pop_front();
          if (word !== exp_tok.word) begin
            $error("word: expected %0d, actual %0d", exp_tok.word, word);
            err_cnt++;
          end
          if (last_word !== exp_tok.last_word) begin
            $error("last_word: expected %0b, actual %0b", exp_tok.last_word, last_word);
            err_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        pop <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Spelled %0d values into %0d checked tokens: directed extremes, random values,",
             n_values, n_tokens);
    $display("a long output stall that filled the block, and back-to-back traffic.");
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== integer_to_word_tokens_core.f =====
sv/i2w_pkg.sv
sv/i2w_front.sv
sv/i2w_queue.sv
sv/i2w_back.sv
sv/integer_to_word_tokens_core.sv
tb/integer_to_word_tokens_core_test.sv
